// ----- rtl/hufpk_pkg.sv -----
// Package for the Huffman table bit packer: sizes, function codes and the
// entry type that passes from the front end to the packing back end.
// No dependencies.
package hufpk_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;

  localparam int BYTE_BITS    = 8;
  localparam int SYM_W        = 8;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int PAD_W        = 3;
  localparam int FUNC_W       = 2;
  localparam int CODE_LIMIT   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int IDX_W        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  localparam int ACC_W        = CODE_W + BYTE_BITS - 1;
  localparam int CNT_W        = $clog2(ACC_W + 1);

  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_t;

  typedef struct packed {
    logic              is_flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } job_t;

endpackage

// ----- rtl/hufpk_if.sv -----
// Valid/ready channel interfaces for the input items and the packed output
// words. Depends on hufpk_pkg for field widths.
interface hufpk_in_if;
  logic                           valid;
  logic                           ready;
  logic [hufpk_pkg::FUNC_W-1:0]   func;
  logic [hufpk_pkg::SYM_W-1:0]    symbol;
  logic [hufpk_pkg::CODE_W-1:0]   code_bits;
  logic [hufpk_pkg::LEN_W-1:0]    code_length;

  modport source (output valid, func, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, func, symbol, code_bits, code_length, output ready);
endinterface

interface hufpk_out_if;
  logic                           valid;
  logic                           ready;
  logic [hufpk_pkg::BYTE_BITS-1:0] out_byte;
  logic                           byte_valid;
  logic [hufpk_pkg::PAD_W-1:0]    pad_count;
  logic                           last;

  modport source (output valid, out_byte, byte_valid, pad_count, last, input ready);
  modport sink   (input valid, out_byte, byte_valid, pad_count, last, output ready);
endinterface

// ----- rtl/huffman_table_bit_packer_core.sv -----
// Huffman table bit packer, top level. Depends on hufpk_pkg, hufpk_if,
// hufpk_front, hufpk_queue and hufpk_back.
// Path: front-end stage register, queue entry, back-end output register.
// Throughput: one input word per cycle while the queue has room; an encode
// of n bytes holds the packer while they leave, one per cycle unless stalled.
// Reset: synchronous, clears control state and the length-table valid bits
// at once; the code table is not cleared and needs no clearing pass.
module huffman_table_bit_packer_core (
  input  logic         clk,
  input  logic         rst_n,
  hufpk_in_if.sink     in_ch,
  hufpk_out_if.source  out_ch
);

  logic            push_valid;
  logic            push_ready;
  hufpk_pkg::job_t push_job;
  logic            pop_valid;
  logic            pop_ready;
  hufpk_pkg::job_t pop_job;

  hufpk_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_func        (in_ch.func),
    .in_symbol      (in_ch.symbol),
    .in_code_bits   (in_ch.code_bits),
    .in_code_length (in_ch.code_length),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_job       (push_job)
  );

  hufpk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  hufpk_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_job        (pop_job),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_byte       (out_ch.out_byte),
    .out_byte_valid (out_ch.byte_valid),
    .out_pad_count  (out_ch.pad_count),
    .out_last       (out_ch.last)
  );

endmodule

// ----- rtl/hufpk_front.sv -----
// Front end: accepts input words, owns the code and length tables, and
// passes encode and flush jobs to the queue. Depends on hufpk_pkg.
module hufpk_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hufpk_pkg::FUNC_W-1:0] in_func,
  input  logic [hufpk_pkg::SYM_W-1:0]  in_symbol,
  input  logic [hufpk_pkg::CODE_W-1:0] in_code_bits,
  input  logic [hufpk_pkg::LEN_W-1:0]  in_code_length,
  output logic                         push_valid,
  input  logic                         push_ready,
  output hufpk_pkg::job_t              push_job
);

  logic [hufpk_pkg::CODE_W-1:0]       code_mem [hufpk_pkg::SYMBOL_COUNT];
  logic [hufpk_pkg::LEN_W-1:0]        len_mem  [hufpk_pkg::SYMBOL_COUNT];
  logic [hufpk_pkg::SYMBOL_COUNT-1:0] len_vld_r;

  logic                         s1_v_r;
  hufpk_pkg::func_t             s1_func_r;
  logic                         s1_sym_ok_r;
  logic [hufpk_pkg::CODE_W-1:0] code_q_r;
  logic [hufpk_pkg::LEN_W-1:0]  len_q_r;
  logic                         lvld_q_r;

  hufpk_pkg::func_t             in_fn;
  logic                         accept;
  logic                         sym_ok;
  logic                         do_load;
  logic [hufpk_pkg::IDX_W-1:0]  idx;
  logic [hufpk_pkg::CODE_W-1:0] mask;
  logic [hufpk_pkg::LEN_W-1:0]  s1_len;
  logic                         s1_keep;

  assign in_fn   = hufpk_pkg::func_t'(in_func);
  assign idx     = in_symbol[hufpk_pkg::IDX_W-1:0];
  assign sym_ok  = {1'b0, in_symbol} < (hufpk_pkg::SYM_W + 1)'(hufpk_pkg::SYMBOL_COUNT);
  assign in_ready = !s1_v_r || !s1_keep || push_ready;
  assign accept  = in_valid && in_ready;
  assign do_load = accept && (in_fn == hufpk_pkg::FUNC_LOAD) && sym_ok &&
                   (in_code_length <= hufpk_pkg::LEN_W'(hufpk_pkg::CODE_LIMIT));

  always_comb begin
    for (int i = 0; i < hufpk_pkg::CODE_W; i++) begin
      mask[i] = hufpk_pkg::LEN_W'(i) < in_code_length;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      code_mem[idx] <= in_code_bits & mask;
      len_mem[idx]  <= in_code_length;
    end
    if (accept) begin
      code_q_r <= code_mem[idx];
      len_q_r  <= len_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_vld_r <= '0;
      lvld_q_r  <= 1'b0;
    end else begin
      if (do_load) begin
        len_vld_r[idx] <= 1'b1;
      end
      if (accept) begin
        lvld_q_r <= len_vld_r[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s1_func_r   <= hufpk_pkg::FUNC_LOAD;
      s1_sym_ok_r <= 1'b0;
    end else if (accept) begin
      s1_v_r      <= (in_fn == hufpk_pkg::FUNC_ENCODE) || (in_fn == hufpk_pkg::FUNC_FLUSH);
      s1_func_r   <= in_fn;
      s1_sym_ok_r <= sym_ok;
    end else if (s1_v_r && (!s1_keep || push_ready)) begin
      s1_v_r <= 1'b0;
    end
  end

  // drop encodes that append nothing
  assign s1_len  = (lvld_q_r && s1_sym_ok_r) ? len_q_r : '0;
  assign s1_keep = (s1_func_r == hufpk_pkg::FUNC_FLUSH) ||
                   ((s1_func_r == hufpk_pkg::FUNC_ENCODE) && (s1_len != '0));

  assign push_valid        = s1_v_r && s1_keep;
  assign push_job.is_flush = (s1_func_r == hufpk_pkg::FUNC_FLUSH);
  assign push_job.code     = (s1_len != '0) ? code_q_r : '0;
  assign push_job.len      = s1_len;

endmodule

// ----- rtl/hufpk_queue.sv -----
// Short job queue between the front end and the packer.
// Depends on hufpk_pkg.
module hufpk_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  hufpk_pkg::job_t push_job,
  output logic            pop_valid,
  input  logic            pop_ready,
  output hufpk_pkg::job_t pop_job
);

  hufpk_pkg::job_t                entries [hufpk_pkg::QUEUE_DEPTH];
  logic [hufpk_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [hufpk_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [hufpk_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = count_r != hufpk_pkg::QCNT_W'(hufpk_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_job    = entries[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == hufpk_pkg::QPTR_W'(hufpk_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == hufpk_pkg::QPTR_W'(hufpk_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/hufpk_back.sv -----
// Back end: merges codes into the bit accumulator; the output register
// gets up to one packed word per cycle if free. Depends on hufpk_pkg.
module hufpk_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  hufpk_pkg::job_t                 pop_job,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hufpk_pkg::BYTE_BITS-1:0] out_byte,
  output logic                            out_byte_valid,
  output logic [hufpk_pkg::PAD_W-1:0]     out_pad_count,
  output logic                            out_last
);

  localparam int BB = hufpk_pkg::BYTE_BITS;

  logic [hufpk_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [hufpk_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                        ov_r;
  logic [BB-1:0]               ob_r;
  logic                        obv_r;
  logic [hufpk_pkg::PAD_W-1:0] opad_r;
  logic                        olast_r;

  logic                        out_free;
  logic                        drain;
  logic                        emit;
  logic [BB-1:0]               e_byte;
  logic                        e_bv;
  logic [hufpk_pkg::PAD_W-1:0] e_pad;
  logic                        e_last;
  logic [hufpk_pkg::ACC_W-1:0] acc_m;
  logic [hufpk_pkg::CNT_W-1:0] total_m;

  assign out_free  = !ov_r || out_ready;
  assign drain     = cnt_r >= hufpk_pkg::CNT_W'(BB);
  assign pop_ready = out_free && !drain;

  assign acc_m   = acc_r | (hufpk_pkg::ACC_W'(pop_job.code) << cnt_r[$clog2(BB)-1:0]);
  assign total_m = cnt_r + hufpk_pkg::CNT_W'(pop_job.len);

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    emit    = 1'b0;
    e_byte  = acc_r[BB-1:0];
    e_bv    = 1'b1;
    e_pad   = '0;
    e_last  = 1'b0;
    priority if (drain && out_free) begin
      emit    = 1'b1;
      e_last  = cnt_r < hufpk_pkg::CNT_W'(2 * BB);
      acc_nxt = acc_r >> BB;
      cnt_nxt = cnt_r - hufpk_pkg::CNT_W'(BB);
    end else if (pop_valid && pop_ready && pop_job.is_flush) begin
      emit    = 1'b1;
      e_last  = 1'b1;
      e_bv    = cnt_r != '0;
      e_pad   = (cnt_r != '0) ? hufpk_pkg::PAD_W'(hufpk_pkg::CNT_W'(BB) - cnt_r) : '0;
      acc_nxt = '0;
      cnt_nxt = '0;
    end else if (pop_valid && pop_ready) begin
      if (total_m >= hufpk_pkg::CNT_W'(BB)) begin
        emit    = 1'b1;
        e_byte  = acc_m[BB-1:0];
        e_last  = total_m < hufpk_pkg::CNT_W'(2 * BB);
        acc_nxt = acc_m >> BB;
        cnt_nxt = total_m - hufpk_pkg::CNT_W'(BB);
      end else begin
        acc_nxt = acc_m;
        cnt_nxt = total_m;
      end
    end else begin
      emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ob_r    <= e_byte;
      obv_r   <= e_bv;
      opad_r  <= e_pad;
      olast_r <= e_last;
    end
  end

  assign out_valid      = ov_r;
  assign out_byte       = ob_r;
  assign out_byte_valid = obv_r;
  assign out_pad_count  = opad_r;
  assign out_last       = olast_r;

endmodule

// ----- rtl/hufpk_checker.sv -----
// Port-level checks on the output channel of the bit packer, and the bind
// that attaches them to the top level. Depends on hufpk_pkg.
module hufpk_port_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [hufpk_pkg::BYTE_BITS-1:0] out_byte,
  input logic                            out_byte_valid,
  input logic [hufpk_pkg::PAD_W-1:0]     out_pad_count,
  input logic                            out_last
);

  a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last && out_byte == '0 && out_pad_count == '0)
    else $error("empty flush word malformed");

  a_pad_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pad_count != '0 |-> out_last && out_byte_valid)
    else $error("pad count on a non-final word");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output word changed");

endmodule

bind huffman_table_bit_packer_core hufpk_port_checker u_hufpk_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_byte       (out_ch.out_byte),
  .out_byte_valid (out_ch.byte_valid),
  .out_pad_count  (out_ch.pad_count),
  .out_last       (out_ch.last)
);
